FILE: hdl/glcw_pkg.sv
// ----------------------------------------------------------------------------
// glcw_pkg: shared types and constants for the grid line cell walker
// Field widths, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package glcw_pkg;

    localparam int TILE_SHIFT_DEF = 5;
    localparam int MAX_CELLS_DEF  = 64;

    localparam int COORD_W   = 15;
    localparam int CELL_W    = 6;
    localparam int INDEX_W   = 10;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     MAP_SIZE_RST   = 6'd32;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;     // capture a new segment
        logic mult;     // form the initial cross products
        logic emit;     // load the output register with the current cell
        logic advance;  // step to the next cell
        logic last;
        logic cut;
    } t_cmd;

    typedef struct packed {
        logic neg;      // current column is negative
        logic at_end;   // current cell is the end cell
    } t_sts;

endpackage

FILE: hdl/glcw_if.sv
// ----------------------------------------------------------------------------
// glcw_seg_if / glcw_cell_if: item channels of the grid line cell walker
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface glcw_seg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [glcw_pkg::COORD_W-1:0]  start_x;
    logic signed [glcw_pkg::COORD_W-1:0]  start_y;
    logic signed [glcw_pkg::COORD_W-1:0]  end_x;
    logic signed [glcw_pkg::COORD_W-1:0]  end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface glcw_cell_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [glcw_pkg::CELL_W-1:0]   cell_x;
    logic signed [glcw_pkg::CELL_W-1:0]   cell_y;
    logic                                 in_map;
    logic [glcw_pkg::INDEX_W-1:0]         cell_index;
    logic                                 truncated;
    logic                                 last;

    modport source (output valid, cell_x, cell_y, in_map, cell_index, truncated, last,
                    input ready);
    modport sink   (input valid, cell_x, cell_y, in_map, cell_index, truncated, last,
                    output ready);
endinterface

FILE: hdl/glcw_ctrl.sv
// ----------------------------------------------------------------------------
// glcw_ctrl: walk sequencer
// Accepts a segment, runs the setup state, then emits one cell per cycle
// while the output register is free, and decides where the path ends.
// ----------------------------------------------------------------------------
module glcw_ctrl #(
    parameter int MAX_CELLS = glcw_pkg::MAX_CELLS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  glcw_pkg::t_sts i_sts,
    output glcw_pkg::t_cmd o_cmd
);
    import glcw_pkg::*;

    localparam int CNT_W = $clog2(MAX_CELLS);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic               out_free;
    logic               stop;

    assign out_free    = !r_out_valid || i_out_ready;
    assign stop        = i_sts.neg || i_sts.at_end || (r_count == CNT_W'(MAX_CELLS - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_count    = '0;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.mult = 1'b1;
                n_state    = S_WALK;
            end
            S_WALK: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = stop;
                    // cap reached with cells still to go
                    o_cmd.cut  = stop && !i_sts.neg && !i_sts.at_end;
                    if (stop) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_count       = r_count + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/glcw_dp.sv
// ----------------------------------------------------------------------------
// glcw_dp: walk datapath
// Holds the current cell, remaining steps and boundary distances per axis.
// The crossing test compares rx*ay against ry*ax; both products are formed
// once at setup; each step advances the one for its axis by a shifted add.
// ----------------------------------------------------------------------------
module glcw_dp #(
    parameter int TILE_SHIFT = glcw_pkg::TILE_SHIFT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  glcw_pkg::t_cmd                      i_cmd,
    output glcw_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic [glcw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [glcw_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [glcw_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [glcw_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [glcw_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [glcw_pkg::COORD_W-1:0] i_end_y,
    output logic signed [glcw_pkg::CELL_W-1:0]  o_cell_x,
    output logic signed [glcw_pkg::CELL_W-1:0]  o_cell_y,
    output logic                                o_in_map,
    output logic [glcw_pkg::INDEX_W-1:0]        o_cell_index,
    output logic                                o_truncated,
    output logic                                o_last
);
    import glcw_pkg::*;

    localparam int S    = TILE_SHIFT + 4;              // pixel fraction + tile bits
    localparam int CW   = COORD_W - S;                 // cell coordinate width
    localparam int DW   = COORD_W + 1;                 // delta / distance width
    localparam int PW   = DW + COORD_W;                // cross product width
    localparam int CMPW = (CW > CELL_W) ? CW : CELL_W;
    localparam int IW2  = 2 * CELL_W;
    localparam logic [DW-1:0] TILE = DW'(1 << S);

    // configuration
    logic [CFG_W-1:0] r_width, r_height;

    // segment setup (combinational from the input item)
    logic signed [COORD_W-1:0] sx_sh, sy_sh, ex_sh, ey_sh;
    logic signed [CW-1:0]      cx0, cy0, ex0, ey0;
    logic signed [CW:0]        ndx, ndy;
    logic [CW-1:0]             nx0, ny0;
    logic signed [DW-1:0]      dx, dy;
    logic [COORD_W-1:0]        ax0, ay0;
    logic [DW-1:0]             fracx, fracy, rx0, ry0;

    // walk state
    logic signed [CW-1:0]      r_cx, r_cy;
    logic [CW-1:0]             r_nx, r_ny;
    logic [DW-1:0]             r_rx, r_ry;
    logic [COORD_W-1:0]        r_ax, r_ay;
    logic                      r_xneg, r_yneg;
    logic [PW-1:0]             r_p, r_q;
    logic                      x_step;
    logic [CW-1:0]             dstep_x, dstep_y;

    // cell output
    logic [CMPW-1:0]           x_u, y_u;
    logic                      in_bounds;
    logic [IW2-1:0]            prod, sum;

    assign sx_sh = i_start_x >>> S;
    assign sy_sh = i_start_y >>> S;
    assign ex_sh = i_end_x >>> S;
    assign ey_sh = i_end_y >>> S;
    assign cx0   = sx_sh[CW-1:0];
    assign cy0   = sy_sh[CW-1:0];
    assign ex0   = ex_sh[CW-1:0];
    assign ey0   = ey_sh[CW-1:0];

    assign ndx = {ex0[CW-1], ex0} - {cx0[CW-1], cx0};
    assign ndy = {ey0[CW-1], ey0} - {cy0[CW-1], cy0};
    assign nx0 = ndx[CW] ? CW'(-ndx) : ndx[CW-1:0];
    assign ny0 = ndy[CW] ? CW'(-ndy) : ndy[CW-1:0];

    assign dx  = DW'(i_end_x) - DW'(i_start_x);
    assign dy  = DW'(i_end_y) - DW'(i_start_y);
    assign ax0 = dx[DW-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    assign ay0 = dy[DW-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];

    // distance to the first boundary in the direction of travel
    assign fracx = DW'(i_start_x[S-1:0]);
    assign fracy = DW'(i_start_y[S-1:0]);
    assign rx0   = dx[DW-1] ? fracx : TILE - fracx;
    assign ry0   = dy[DW-1] ? fracy : TILE - fracy;

    // x first on an exact corner crossing
    assign x_step  = (r_nx != '0) && ((r_ny == '0) || (r_p <= r_q));
    assign dstep_x = r_xneg ? '1 : CW'(1);
    assign dstep_y = r_yneg ? '1 : CW'(1);

    assign o_sts = '{neg: r_cx[CW-1], at_end: (r_nx == '0) && (r_ny == '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MAP_SIZE_RST;
            r_height <= MAP_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAP_WIDTH:  r_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= cx0;
            r_cy   <= cy0;
            r_nx   <= nx0;
            r_ny   <= ny0;
            r_rx   <= rx0;
            r_ry   <= ry0;
            r_ax   <= ax0;
            r_ay   <= ay0;
            r_xneg <= (dx[DW-1] || (dx == '0));
            r_yneg <= (dy[DW-1] || (dy == '0));
        end else if (i_cmd.mult) begin
            r_p <= PW'(r_rx) * PW'(r_ay);
            r_q <= PW'(r_ry) * PW'(r_ax);
        end else if (i_cmd.advance) begin
            if (x_step) begin
                r_cx <= r_cx + dstep_x;
                r_nx <= r_nx - CW'(1);
                r_p  <= r_p + (PW'(r_ay) << S);
            end else begin
                r_cy <= r_cy + dstep_y;
                r_ny <= r_ny - CW'(1);
                r_q  <= r_q + (PW'(r_ax) << S);
            end
        end
    end

    assign x_u       = CMPW'($unsigned(r_cx));
    assign y_u       = CMPW'($unsigned(r_cy));
    assign in_bounds = !r_cx[CW-1] && !r_cy[CW-1]
                       && (x_u < CMPW'(r_width)) && (y_u < CMPW'(r_height));
    assign prod      = IW2'(y_u[CELL_W-1:0]) * IW2'(r_width);
    assign sum       = prod + IW2'(x_u[CELL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_cell_x     <= CELL_W'(r_cx);
            o_cell_y     <= CELL_W'(r_cy);
            o_in_map     <= in_bounds;
            o_cell_index <= in_bounds ? sum[INDEX_W-1:0] : '0;
            o_truncated  <= i_cmd.cut;
            o_last       <= i_cmd.last;
        end
    end

endmodule

FILE: hdl/grid_line_cell_walker.sv
// ----------------------------------------------------------------------------
// grid_line_cell_walker: 4-connected grid cells along a line segment
// Order: the segment is loaded, setup forms the products, walk emits cells.
// Throughput: one cell per cycle unless the output stalls; a segment of N cells
// (N <= MAX_CELLS) holds the input to the end: glcw_dp has a single stepper.
// Reset: synchronous active low; clears the sequencer, map size back to 32.
// ----------------------------------------------------------------------------
module grid_line_cell_walker #(
    parameter int TILE_SHIFT = glcw_pkg::TILE_SHIFT_DEF,
    parameter int MAX_CELLS  = glcw_pkg::MAX_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    glcw_seg_if.sink                       i_seg,
    glcw_cell_if.source                    o_cell,
    input  logic                           i_cfg_we,
    input  logic [glcw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [glcw_pkg::CFG_W-1:0]     i_cfg_data
);
    import glcw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    glcw_ctrl #(
        .MAX_CELLS (MAX_CELLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_seg.valid),
        .o_in_ready  (i_seg.ready),
        .o_out_valid (o_cell.valid),
        .i_out_ready (o_cell.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    glcw_dp #(
        .TILE_SHIFT (TILE_SHIFT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start_x    (i_seg.start_x),
        .i_start_y    (i_seg.start_y),
        .i_end_x      (i_seg.end_x),
        .i_end_y      (i_seg.end_y),
        .o_cell_x     (o_cell.cell_x),
        .o_cell_y     (o_cell.cell_y),
        .o_in_map     (o_cell.in_map),
        .o_cell_index (o_cell.cell_index),
        .o_truncated  (o_cell.truncated),
        .o_last       (o_cell.last)
    );

endmodule

FILE: hdl/glcw_checker.sv
// ----------------------------------------------------------------------------
// glcw_checker: port-level checks for the grid line cell walker
// Watches the item channels only; bound onto the top level.
// ----------------------------------------------------------------------------
module glcw_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [glcw_pkg::CELL_W-1:0]  i_cell_x,
    input  logic signed [glcw_pkg::CELL_W-1:0]  i_cell_y,
    input  logic                                i_in_map,
    input  logic [glcw_pkg::INDEX_W-1:0]        i_cell_index,
    input  logic                                i_truncated,
    input  logic                                i_last
);
    import glcw_pkg::*;

    // a stalled cell stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
        && $stable({i_cell_x, i_cell_y, i_in_map, i_cell_index, i_truncated, i_last}))
        else $error("output item changed while stalled");

    // one segment at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("segment accepted while walk pending");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_truncated |-> i_last)
        else $error("truncated flag on a non-final cell");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_in_map |-> (i_cell_index == '0))
        else $error("nonzero index for a cell outside the map");

endmodule

bind grid_line_cell_walker glcw_checker u_glcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_seg.valid),
    .i_in_ready   (i_seg.ready),
    .i_out_valid  (o_cell.valid),
    .i_out_ready  (o_cell.ready),
    .i_cell_x     (o_cell.cell_x),
    .i_cell_y     (o_cell.cell_y),
    .i_in_map     (o_cell.in_map),
    .i_cell_index (o_cell.cell_index),
    .i_truncated  (o_cell.truncated),
    .i_last       (o_cell.last)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: grid line cell walker
// Sends line segments over the valid/ready input, predicts the cell path of
// each one, and checks every emitted cell in order against the prediction.
// Map size is changed between phases while the walker is idle; both sides
// idle at random, and the output is held off for a long stretch twice.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic signed [glcw_pkg::COORD_W-1:0] sx;
    logic signed [glcw_pkg::COORD_W-1:0] sy;
    logic signed [glcw_pkg::COORD_W-1:0] ex;
    logic signed [glcw_pkg::COORD_W-1:0] ey;
} t_seg;

typedef struct packed {
    logic signed [glcw_pkg::CELL_W-1:0] cell_x;
    logic signed [glcw_pkg::CELL_W-1:0] cell_y;
    logic                               in_map;
    logic [glcw_pkg::INDEX_W-1:0]       cell_index;
    logic                               truncated;
    logic                               last;
} t_cell;

class cell_path_board;
    localparam int PIX_SHIFT = glcw_pkg::TILE_SHIFT_DEF + 4;  // 4 fraction bits
    localparam int CAP       = glcw_pkg::MAX_CELLS_DEF;

    t_cell path_cells[$];
    int    map_w  = 32;
    int    map_h  = 32;
    int    errors = 0;
    int    cells_seen = 0;

    function int pending();
        return path_cells.size();
    endfunction

    task report_miss(string what);
        $display("cell %0d: %s", cells_seen, what);
        errors++;
    endtask

    // Walk the segment cell by cell; the cross products pick the boundary
    // the line reaches first, ties go to the x step.
    function void note_segment(t_seg seg);
        longint sx, sy, fx, fy, cx, cy, tx, ty;
        longint dx, dy, ax, ay, nx, ny, stx, sty, rx, ry, tile, idx;
        int     count;
        bit     cut;
        t_cell  c;
        tile = longint'(1) << PIX_SHIFT;
        sx = seg.sx;  sy = seg.sy;
        fx = seg.ex;  fy = seg.ey;
        cx = sx >>> PIX_SHIFT;  cy = sy >>> PIX_SHIFT;
        tx = fx >>> PIX_SHIFT;  ty = fy >>> PIX_SHIFT;
        dx = fx - sx;  dy = fy - sy;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        nx = tx > cx ? tx - cx : cx - tx;
        ny = ty > cy ? ty - cy : cy - ty;
        stx = dx > 0 ? 1 : -1;
        sty = dy > 0 ? 1 : -1;
        rx = dx >= 0 ? (cx + 1) * tile - sx : sx - cx * tile;
        ry = dy >= 0 ? (cy + 1) * tile - sy : sy - cy * tile;
        count = 0;
        cut = 0;
        while (1) begin
            c.cell_x     = cx[glcw_pkg::CELL_W-1:0];
            c.cell_y     = cy[glcw_pkg::CELL_W-1:0];
            c.in_map     = cx >= 0 && cy >= 0 && cx < map_w && cy < map_h;
            idx          = cx + cy * map_w;
            c.cell_index = c.in_map ? idx[glcw_pkg::INDEX_W-1:0] : '0;
            c.truncated  = 1'b0;
            c.last       = 1'b0;
            path_cells.insert(path_cells.size(), c);
            count++;
            if (cx < 0) break;
            if (nx == 0 && ny == 0) break;
            if (count >= CAP) begin
                cut = 1;
                break;
            end
            if (nx > 0 && (ny == 0 || rx * ay <= ry * ax)) begin
                cx += stx;
                rx += tile;
                nx--;
            end else begin
                cy += sty;
                ry += tile;
                ny--;
            end
        end
        path_cells[path_cells.size() - 1].truncated = cut;
        path_cells[path_cells.size() - 1].last      = 1'b1;
    endfunction

    task check_cell(t_cell got);
        t_cell want;
        cells_seen++;
        if (path_cells.size() == 0) begin
            report_miss("cell arrived with nothing expected");
            return;
        end
        want = path_cells.pop_front();
        if (got.cell_x !== want.cell_x)
            report_miss($sformatf("cell_x got %0d want %0d", got.cell_x, want.cell_x));
        if (got.cell_y !== want.cell_y)
            report_miss($sformatf("cell_y got %0d want %0d", got.cell_y, want.cell_y));
        if (got.in_map !== want.in_map)
            report_miss($sformatf("in_map got %b want %b", got.in_map, want.in_map));
        if (got.cell_index !== want.cell_index)
            report_miss($sformatf("cell_index got %0d want %0d",
                                  got.cell_index, want.cell_index));
        if (got.truncated !== want.truncated)
            report_miss($sformatf("truncated got %b want %b", got.truncated, want.truncated));
        if (got.last !== want.last)
            report_miss($sformatf("last got %b want %b", got.last, want.last));
    endtask
endclass

module testbench;
    import glcw_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 10;
    localparam int PHASE_ITEMS  = 50;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    glcw_seg_if  seg_bus ();
    glcw_cell_if cell_bus ();

    grid_line_cell_walker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seg      (seg_bus),
        .o_cell     (cell_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cell_path_board board = new();

    bit send_steady = 0;
    bit recv_steady = 0;
    bit hold_request = 0;
    int quiet = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // monitors: note accepted segments, check accepted cells
    always @(posedge i_clk) begin
        if (seg_bus.valid && seg_bus.ready)
            board.note_segment('{seg_bus.start_x, seg_bus.start_y,
                                 seg_bus.end_x, seg_bus.end_y});
        if (cell_bus.valid && cell_bus.ready)
            board.check_cell('{cell_bus.cell_x, cell_bus.cell_y, cell_bus.in_map,
                               cell_bus.cell_index, cell_bus.truncated, cell_bus.last});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_bus.valid && seg_bus.ready) ||
            (cell_bus.valid && cell_bus.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        int stall;
        cell_bus.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(15) == 0) recv_steady = !recv_steady;
            if (hold_request) begin
                hold_request = 0;
                stall = HOLD_CYCLES;
            end else begin
                stall = recv_steady ? 0 : $urandom_range(17);
            end
            if (stall > 0) begin
                cell_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            cell_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!cell_bus.valid);
        end
    end

    function automatic int coord_in(int lo, int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    function automatic int clamp_coord(int v);
        return v < -16384 ? -16384 : (v > 16383 ? 16383 : v);
    endfunction

    function automatic t_seg make_seg(int sx, int sy, int ex, int ey);
        t_seg s;
        s.sx = COORD_W'(sx);
        s.sy = COORD_W'(sy);
        s.ex = COORD_W'(ex);
        s.ey = COORD_W'(ey);
        return s;
    endfunction

    // Half are walks that start at a nonnegative column so they run long;
    // the rest are short hops, corner-aligned diagonals, flat lines and noise.
    function automatic t_seg random_segment();
        int kind, sx, sy, ex, ey, k, off;
        kind = $urandom_range(99);
        if (kind < 50) begin
            sx = coord_in(0, 16383);
            sy = coord_in(-16384, 16383);
            ex = coord_in(0, 16383);
            ey = coord_in(-16384, 16383);
        end else if (kind < 65) begin
            sx = coord_in(0, 16383);
            sy = coord_in(-16384, 16383);
            ex = clamp_coord(sx + coord_in(-1500, 1500));
            ey = clamp_coord(sy + coord_in(-1500, 1500));
        end else if (kind < 77) begin
            k   = coord_in(1, 3);
            off = $urandom_range(1) ? 256 * $urandom_range(1) : coord_in(0, 511);
            sx  = coord_in(3, 28) * 512 + off;
            sy  = coord_in(-29, 28) * 512 + off;
            ex  = sx + ($urandom_range(1) ? k : -k) * 512;
            ey  = sy + ($urandom_range(1) ? k : -k) * 512;
        end else if (kind < 87) begin
            sx = coord_in(0, 16383);
            sy = coord_in(-16384, 16383);
            if ($urandom_range(1)) begin
                ex = sx;
                ey = coord_in(-16384, 16383);
            end else begin
                ex = coord_in(-16384, 16383);
                ey = sy;
            end
        end else begin
            sx = coord_in(-16384, 16383);
            sy = coord_in(-16384, 16383);
            ex = coord_in(-16384, 16383);
            ey = coord_in(-16384, 16383);
        end
        return make_seg(sx, sy, ex, ey);
    endfunction

    // Starts just after a rising clock; returns once the item is taken.
    task automatic send_segment(t_seg s);
        int gap;
        if ($urandom_range(15) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(17);
        if (gap > 0) begin
            seg_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_bus.valid   <= 1'b1;
        seg_bus.start_x <= s.sx;
        seg_bus.start_y <= s.sy;
        seg_bus.end_x   <= s.ex;
        seg_bus.end_y   <= s.ey;
        do @(posedge i_clk); while (!seg_bus.ready);
    endtask

    task automatic drain();
        seg_bus.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic set_map(int w, int h);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MAP_WIDTH;
        i_cfg_data <= CFG_W'(w);
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAP_HEIGHT;
        i_cfg_data <= CFG_W'(h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.map_w = w;
        board.map_h = h;
    endtask

    initial begin
        int map_sizes[6][2];
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= REG_MAP_WIDTH;
        i_cfg_data       <= '0;
        seg_bus.valid    <= 1'b0;
        seg_bus.start_x  <= '0;
        seg_bus.start_y  <= '0;
        seg_bus.end_x    <= '0;
        seg_bus.end_y    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset map size
        send_segment(make_seg(100, 100, 200, 300));            // same cell
        send_segment(make_seg(256, 256, 1792, 1792));          // through corners
        send_segment(make_seg(1792, 1792, 256, 256));          // corners, backwards
        send_segment(make_seg(0, 1000, 16383, 1000));          // flat, full width
        send_segment(make_seg(5000, 16383, 5000, -16384));     // 64 cells, not cut
        send_segment(make_seg(0, -16384, 16383, 16383));       // cut at the cap
        send_segment(make_seg(-16384, -16384, 16383, 16383));  // negative start
        send_segment(make_seg(16383, 16383, -16384, -16384));  // runs into x < 0
        send_segment(make_seg(16383, -16384, 16383, 16383));
        send_segment(make_seg(-1, 0, 5000, 0));
        send_segment(make_seg(0, 0, 0, 0));
        send_segment(make_seg(0, 512, -1, 512));
        send_segment(make_seg(9000, 300, 600, 300));
        send_segment(make_seg(700, -3000, 1300, 9000));
        send_segment(make_seg(16383, 0, 0, 16383));
        send_segment(make_seg(15877, 15877, 16383, 16383));    // far corner of map
        send_segment(make_seg(3000, -16384, 3100, -15000));
        send_segment(make_seg(-16384, 16383, -16384, 16383));
        send_segment(make_seg(1000, 16383, 1000, -100));
        send_segment(make_seg(512, 512, 2048, 1024));          // corner with shallow slope
        send_segment(make_seg(16383, 511, 16383, 512));

        map_sizes = '{'{32, 32}, '{1, 1}, '{63, 63}, '{0, 32}, '{32, 0}, '{0, 0}};
        map_sizes[5][0] = $urandom_range(63);
        map_sizes[5][1] = $urandom_range(63);
        for (int p = 0; p < 6; p++) begin
            set_map(map_sizes[p][0], map_sizes[p][1]);
            if (p == 1 || p == 4) hold_request = 1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2 && p % 2 == 0) drain();
                send_segment(random_segment());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/glcw_pkg.sv
hdl/glcw_if.sv
hdl/glcw_ctrl.sv
hdl/glcw_dp.sv
hdl/grid_line_cell_walker.sv
hdl/glcw_checker.sv
test/testbench.sv
